>>> rtl/suvm_pkg.sv
// ----------------------------------------------------------------------------
// Spherical UV mapper package
// Field widths, internal widths, the CORDIC turn table and shared word types.
// ----------------------------------------------------------------------------
package suvm_pkg;

  localparam int COORD_BITS = 24;
  localparam int UV_BITS    = 16;
  localparam int ROT_STEPS  = 28;

  localparam int CW        = 36;
  localparam int ANG_W     = 34;
  localparam int AC_W      = 33;
  localparam int S_W       = 64;
  localparam int P_W       = $clog2(S_W);
  localparam int MAG_NORM  = 30;
  localparam int S_NORM    = 60;
  localparam int SH_W      = $clog2(MAG_NORM + 1);
  localparam int K_W       = $clog2(S_NORM / 2 + 1);
  localparam int ROOT_W    = S_W / 2;
  localparam int REM_W     = ROOT_W + 2;
  localparam int W_W       = ROOT_W + 1;
  localparam int N_W       = W_W + 1 + UV_BITS;
  localparam int Q_W       = UV_BITS + 1;

  localparam logic signed [ANG_W-1:0] ANG_HALF = ANG_W'(64'h8000_0000);
  localparam logic signed [ANG_W-1:0] ANG_ONE  = ANG_W'(64'h1_0000_0000);
  localparam logic [AC_W:0]           U_RND    = (AC_W + 1)'(64'd1 << (31 - UV_BITS));
  localparam logic [UV_BITS-1:0]      UV_TOP   = '1;
  localparam logic [UV_BITS-1:0]      UV_HALF  = UV_BITS'(1) << (UV_BITS - 1);

  localparam logic [31:0] TURN_TAB [ROT_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5
  };

  typedef struct packed {
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] pos_z;
  } pos_t;

  typedef struct packed {
    logic [UV_BITS-1:0] tex_u;
    logic [UV_BITS-1:0] tex_v;
    logic               degenerate;
  } uv_t;

  typedef struct packed {
    logic vld;
    logic degen;
  } ctl_t;

  typedef struct packed {
    logic                  y_neg;
    logic [COORD_BITS-1:0] y_mag;
    logic [K_W-1:0]        k;
  } aux_t;

endpackage

>>> rtl/spherical_uv_mapper_unit.sv
// ----------------------------------------------------------------------------
// Spherical UV mapper
// Vertex position in, spherical texture coordinates out, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive pos_i and raise start; the word is taken at every
//   rising edge with start high and busy low. busy stays low, so one vertex
//   can be taken in every cycle.
//   Output channel: valid_o is high for exactly one cycle with uv_o holding
//   tex_u, tex_v and the degenerate flag. The receiver cannot hold results
//   off; results leave in input order.
//   Pipeline: the result passes through 3 front stages, 32 square-root cells,
//   one rescale stage, 17 divider cells and one output register.
//   Throughput: one vertex per cycle, set by the cell chains, each advancing
//   one step per cycle.
//   The azimuth runs through a 28-cell CORDIC chain and is delayed to meet
//   the elevation chain.
//   Reset: rst_ni clears every valid bit at once; the block takes words in
//   the first cycle after reset is released and needs no clearing pass.
// ----------------------------------------------------------------------------
module spherical_uv_mapper_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  suvm_pkg::pos_t pos_i,
  output logic           busy,
  output logic           valid_o,
  output suvm_pkg::uv_t  uv_o
);
  import suvm_pkg::*;

  localparam int SQ_N    = ROOT_W;
  localparam int AZ_DLY  = SQ_N + 1 + Q_W - ROT_STEPS;
  localparam int LATENCY = 3 + SQ_N + 1 + Q_W + 1;

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  ctl_t                    fr_ctl;
  logic                    fr_axis;
  logic signed [CW-1:0]    fr_cx, fr_cy;
  logic signed [ANG_W-1:0] fr_ang;
  logic [S_W-1:0]          fr_sv;
  aux_t                    fr_aux;

  suvm_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .pos_i   (pos_i),
    .ctl_o   (fr_ctl),
    .axis_o  (fr_axis),
    .cx_o    (fr_cx),
    .cy_o    (fr_cy),
    .ang_o   (fr_ang),
    .sv_o    (fr_sv),
    .aux_o   (fr_aux)
  );

  logic                    cor_axis [ROT_STEPS+1];
  logic signed [CW-1:0]    cor_cx   [ROT_STEPS+1];
  logic signed [CW-1:0]    cor_cy   [ROT_STEPS+1];
  logic signed [ANG_W-1:0] cor_ang  [ROT_STEPS+1];

  assign cor_axis[0] = fr_axis;
  assign cor_cx[0]   = fr_cx;
  assign cor_cy[0]   = fr_cy;
  assign cor_ang[0]  = fr_ang;

  for (genvar g = 0; g < ROT_STEPS; g++) begin : g_cordic
    suvm_cordic_cell #(.STEP(g)) u_cell (
      .clk_i  (clk_i),
      .axis_i (cor_axis[g]),
      .cx_i   (cor_cx[g]),
      .cy_i   (cor_cy[g]),
      .ang_i  (cor_ang[g]),
      .axis_o (cor_axis[g+1]),
      .cx_o   (cor_cx[g+1]),
      .cy_o   (cor_cy[g+1]),
      .ang_o  (cor_ang[g+1])
    );
  end

  logic signed [ANG_W-1:0] a_sum;
  logic [AC_W-1:0]         a_clip;
  logic [AC_W:0]           u_full;
  logic [UV_BITS-1:0]      u_d;

  always_comb begin
    a_sum = cor_ang[ROT_STEPS] + ANG_HALF;
    if (a_sum[ANG_W-1]) begin
      a_clip = '0;
    end else if (a_sum > ANG_ONE) begin
      a_clip = ANG_ONE[AC_W-1:0];
    end else begin
      a_clip = a_sum[AC_W-1:0];
    end
    u_full = ((AC_W + 1)'(a_clip) + U_RND) >> (32 - UV_BITS);
    if (cor_axis[ROT_STEPS]) begin
      u_d = UV_HALF;
    end else if (u_full > (AC_W + 1)'(UV_TOP)) begin
      u_d = UV_TOP;
    end else begin
      u_d = u_full[UV_BITS-1:0];
    end
  end

  logic [UV_BITS-1:0] az_q [AZ_DLY];

  always_ff @(posedge clk_i) begin
    az_q[0] <= u_d;
    for (int i = 1; i < AZ_DLY; i++) begin
      az_q[i] <= az_q[i-1];
    end
  end

  ctl_t              sq_ctl  [SQ_N+1];
  aux_t              sq_aux  [SQ_N+1];
  logic [S_W-1:0]    sq_sv   [SQ_N+1];
  logic [REM_W-1:0]  sq_rem  [SQ_N+1];
  logic [ROOT_W-1:0] sq_root [SQ_N+1];

  assign sq_ctl[0]  = fr_ctl;
  assign sq_aux[0]  = fr_aux;
  assign sq_sv[0]   = fr_sv;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;

  for (genvar g = 0; g < SQ_N; g++) begin : g_sqrt
    suvm_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (sq_ctl[g]),
      .aux_i  (sq_aux[g]),
      .sv_i   (sq_sv[g]),
      .rem_i  (sq_rem[g]),
      .root_i (sq_root[g]),
      .ctl_o  (sq_ctl[g+1]),
      .aux_o  (sq_aux[g+1]),
      .sv_o   (sq_sv[g+1]),
      .rem_o  (sq_rem[g+1]),
      .root_o (sq_root[g+1])
    );
  end

  logic [W_W-1:0] yk, w;
  logic [N_W-1:0] n_d;
  ctl_t           wq_ctl_q;
  logic [N_W-1:0] n_q;
  logic [W_W-1:0] d_q;

  always_comb begin
    yk  = W_W'(sq_aux[SQ_N].y_mag) << sq_aux[SQ_N].k;
    w   = sq_aux[SQ_N].y_neg ? (W_W'(sq_root[SQ_N]) - yk) : (W_W'(sq_root[SQ_N]) + yk);
    n_d = (N_W'(w) << UV_BITS) + N_W'(sq_root[SQ_N]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wq_ctl_q <= '0;
    end else begin
      wq_ctl_q <= sq_ctl[SQ_N];
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d;
    d_q <= {sq_root[SQ_N], 1'b0};
  end

  ctl_t           dv_ctl [Q_W+1];
  logic [N_W-1:0] dv_rem [Q_W+1];
  logic [W_W-1:0] dv_d   [Q_W+1];
  logic [Q_W-1:0] dv_q   [Q_W+1];

  assign dv_ctl[0] = wq_ctl_q;
  assign dv_rem[0] = n_q;
  assign dv_d[0]   = d_q;
  assign dv_q[0]   = '0;

  for (genvar g = 0; g < Q_W; g++) begin : g_div
    suvm_div_cell #(.BIT(UV_BITS - g)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (dv_ctl[g]),
      .rem_i  (dv_rem[g]),
      .d_i    (dv_d[g]),
      .q_i    (dv_q[g]),
      .ctl_o  (dv_ctl[g+1]),
      .rem_o  (dv_rem[g+1]),
      .d_o    (dv_d[g+1]),
      .q_o    (dv_q[g+1])
    );
  end

  uv_t  uv_d, uv_q;
  logic vld_q;

  always_comb begin
    uv_d.tex_u      = az_q[AZ_DLY-1];
    uv_d.degenerate = dv_ctl[Q_W].degen;
    if (dv_ctl[Q_W].degen) begin
      uv_d.tex_v = UV_HALF;
    end else if (dv_q[Q_W] > Q_W'(UV_TOP)) begin
      uv_d.tex_v = UV_TOP;
    end else begin
      uv_d.tex_v = dv_q[Q_W][UV_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= dv_ctl[Q_W].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    uv_q <= uv_d;
  end

  assign valid_o = vld_q;
  assign uv_o    = uv_q;

  a_lat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(accept, LATENCY))
    else $error("result word without an accepted vertex");

  a_degen_half : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && uv_o.degenerate |-> (uv_o.tex_u == UV_HALF) && (uv_o.tex_v == UV_HALF))
    else $error("degenerate word without default coordinates");

  a_degen_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (uv_o.degenerate == $past(pos_i == '0, LATENCY)))
    else $error("degenerate flag does not match the input vertex");

endmodule

>>> rtl/suvm_front.sv
// ----------------------------------------------------------------------------
// Spherical UV mapper front end
// Three stages: magnitudes and squares, CORDIC start vector and norm of the
// squared length, then the even normalizing shift for the root chain.
// ----------------------------------------------------------------------------
module suvm_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  suvm_pkg::pos_t                      pos_i,
  output suvm_pkg::ctl_t                      ctl_o,
  output logic                                axis_o,
  output logic signed [suvm_pkg::CW-1:0]      cx_o,
  output logic signed [suvm_pkg::CW-1:0]      cy_o,
  output logic signed [suvm_pkg::ANG_W-1:0]   ang_o,
  output logic [suvm_pkg::S_W-1:0]            sv_o,
  output suvm_pkg::aux_t                      aux_o
);
  import suvm_pkg::*;

  localparam int SQ_W = 2 * COORD_BITS;

  function automatic logic [P_W-1:0] msb_pos(logic [S_W-1:0] v);
    logic [P_W-1:0] p;
    p = '0;
    for (int i = 0; i < S_W; i++) begin
      if (v[i]) p = P_W'(i);
    end
    return p;
  endfunction

  function automatic logic [COORD_BITS-1:0] mag(logic signed [COORD_BITS-1:0] v);
    return v[COORD_BITS-1] ? $unsigned(-v) : $unsigned(v);
  endfunction

  logic [COORD_BITS-1:0] ax, ay, az, m;
  logic [P_W-1:0]        mp;
  logic [SH_W-1:0]       s1_d;

  ctl_t                         ctl1_q;
  logic                         axis1_q;
  logic signed [COORD_BITS-1:0] x1_q, z1_q;
  logic                         yneg1_q;
  logic [COORD_BITS-1:0]        ay1_q;
  logic [SH_W-1:0]              s1_q;
  logic [SQ_W-1:0]              sqx_q, sqy_q, sqz_q;

  always_comb begin
    ax = mag(pos_i.pos_x);
    ay = mag(pos_i.pos_y);
    az = mag(pos_i.pos_z);
    m  = (ax > az) ? ax : az;
    mp = msb_pos(S_W'(m));
    s1_d = (int'(mp) >= MAG_NORM) ? '0 : SH_W'(MAG_NORM - int'(mp));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
    end else begin
      ctl1_q.vld   <= valid_i;
      ctl1_q.degen <= (pos_i == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    axis1_q <= (m == '0);
    x1_q    <= pos_i.pos_x;
    z1_q    <= pos_i.pos_z;
    yneg1_q <= pos_i.pos_y[COORD_BITS-1];
    ay1_q   <= ay;
    s1_q    <= s1_d;
    sqx_q   <= ax * ax;
    sqy_q   <= ay * ay;
    sqz_q   <= az * az;
  end

  logic signed [CW-1:0]    czs, cxs;
  logic signed [CW-1:0]    cx2_d, cy2_d;
  logic signed [ANG_W-1:0] ang2_d;
  logic [S_W-1:0]          ssum;
  logic [P_W-1:0]          sp;
  logic [K_W-1:0]          k2_d;

  always_comb begin
    czs  = $signed({{(CW-COORD_BITS){z1_q[COORD_BITS-1]}}, z1_q}) <<< s1_q;
    cxs  = $signed({{(CW-COORD_BITS){x1_q[COORD_BITS-1]}}, x1_q}) <<< s1_q;
    if (czs[CW-1]) begin
      cx2_d  = -czs;
      cy2_d  = -cxs;
      ang2_d = x1_q[COORD_BITS-1] ? -ANG_HALF : ANG_HALF;
    end else begin
      cx2_d  = czs;
      cy2_d  = cxs;
      ang2_d = '0;
    end
    ssum = S_W'(sqx_q) + S_W'(sqy_q) + S_W'(sqz_q);
    sp   = msb_pos(ssum);
    k2_d = (int'(sp) >= S_NORM) ? '0 : K_W'((S_NORM + 1 - int'(sp)) >> 1);
  end

  ctl_t                    ctl2_q;
  logic                    axis2_q;
  logic signed [CW-1:0]    cx2_q, cy2_q;
  logic signed [ANG_W-1:0] ang2_q;
  logic [S_W-1:0]          s2_q;
  aux_t                    aux2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl2_q <= '0;
    end else begin
      ctl2_q <= ctl1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    axis2_q      <= axis1_q;
    cx2_q        <= cx2_d;
    cy2_q        <= cy2_d;
    ang2_q       <= ang2_d;
    s2_q         <= ssum;
    aux2_q.y_neg <= yneg1_q;
    aux2_q.y_mag <= ay1_q;
    aux2_q.k     <= k2_d;
  end

  ctl_t                    ctl3_q;
  logic                    axis3_q;
  logic signed [CW-1:0]    cx3_q, cy3_q;
  logic signed [ANG_W-1:0] ang3_q;
  logic [S_W-1:0]          sv3_q;
  aux_t                    aux3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl3_q <= '0;
    end else begin
      ctl3_q <= ctl2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    axis3_q <= axis2_q;
    cx3_q   <= cx2_q;
    cy3_q   <= cy2_q;
    ang3_q  <= ang2_q;
    sv3_q   <= s2_q << {aux2_q.k, 1'b0};
    aux3_q  <= aux2_q;
  end

  assign ctl_o  = ctl3_q;
  assign axis_o = axis3_q;
  assign cx_o   = cx3_q;
  assign cy_o   = cy3_q;
  assign ang_o  = ang3_q;
  assign sv_o   = sv3_q;
  assign aux_o  = aux3_q;

endmodule

>>> rtl/suvm_cordic_cell.sv
// ----------------------------------------------------------------------------
// Spherical UV mapper CORDIC cell
// One vectoring rotation step toward the positive x axis, angle in turns.
// ----------------------------------------------------------------------------
module suvm_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic                              clk_i,
  input  logic                              axis_i,
  input  logic signed [suvm_pkg::CW-1:0]    cx_i,
  input  logic signed [suvm_pkg::CW-1:0]    cy_i,
  input  logic signed [suvm_pkg::ANG_W-1:0] ang_i,
  output logic                              axis_o,
  output logic signed [suvm_pkg::CW-1:0]    cx_o,
  output logic signed [suvm_pkg::CW-1:0]    cy_o,
  output logic signed [suvm_pkg::ANG_W-1:0] ang_o
);
  import suvm_pkg::*;

  localparam logic signed [ANG_W-1:0] TURN = $signed({{(ANG_W-32){1'b0}}, TURN_TAB[STEP]});

  logic signed [CW-1:0] dx, dy;
  logic                 up;
  logic                 axis_q;
  logic signed [CW-1:0] cx_q, cy_q;
  logic signed [ANG_W-1:0] ang_q;

  assign dx = cy_i >>> STEP;
  assign dy = cx_i >>> STEP;
  assign up = !cy_i[CW-1] && (cy_i != '0);

  always_ff @(posedge clk_i) begin
    axis_q <= axis_i;
    if (up) begin
      cx_q  <= cx_i + dx;
      cy_q  <= cy_i - dy;
      ang_q <= ang_i + TURN;
    end else begin
      cx_q  <= cx_i - dx;
      cy_q  <= cy_i + dy;
      ang_q <= ang_i - TURN;
    end
  end

  assign axis_o = axis_q;
  assign cx_o   = cx_q;
  assign cy_o   = cy_q;
  assign ang_o  = ang_q;

endmodule

>>> rtl/suvm_sqrt_cell.sv
// ----------------------------------------------------------------------------
// Spherical UV mapper square-root cell
// Takes two radicand bits and settles one root bit, restoring form.
// ----------------------------------------------------------------------------
module suvm_sqrt_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  suvm_pkg::ctl_t                 ctl_i,
  input  suvm_pkg::aux_t                 aux_i,
  input  logic [suvm_pkg::S_W-1:0]       sv_i,
  input  logic [suvm_pkg::REM_W-1:0]     rem_i,
  input  logic [suvm_pkg::ROOT_W-1:0]    root_i,
  output suvm_pkg::ctl_t                 ctl_o,
  output suvm_pkg::aux_t                 aux_o,
  output logic [suvm_pkg::S_W-1:0]       sv_o,
  output logic [suvm_pkg::REM_W-1:0]     rem_o,
  output logic [suvm_pkg::ROOT_W-1:0]    root_o
);
  import suvm_pkg::*;

  logic [REM_W+1:0]  rn, t;
  logic              ge;
  ctl_t              ctl_q;
  aux_t              aux_q;
  logic [S_W-1:0]    sv_q;
  logic [REM_W-1:0]  rem_q;
  logic [ROOT_W-1:0] root_q;

  assign rn = {rem_i, sv_i[S_W-1 -: 2]};
  assign t  = (REM_W + 2)'({root_i, 2'b01});
  assign ge = (rn >= t);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    aux_q  <= aux_i;
    sv_q   <= sv_i << 2;
    rem_q  <= ge ? REM_W'(rn - t) : rn[REM_W-1:0];
    root_q <= {root_i[ROOT_W-2:0], ge};
  end

  assign ctl_o  = ctl_q;
  assign aux_o  = aux_q;
  assign sv_o   = sv_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;

endmodule

>>> rtl/suvm_div_cell.sv
// ----------------------------------------------------------------------------
// Spherical UV mapper divider cell
// One restoring quotient bit against the divisor at a fixed bit weight.
// ----------------------------------------------------------------------------
module suvm_div_cell #(
  parameter int BIT = 0
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  suvm_pkg::ctl_t              ctl_i,
  input  logic [suvm_pkg::N_W-1:0]    rem_i,
  input  logic [suvm_pkg::W_W-1:0]    d_i,
  input  logic [suvm_pkg::Q_W-1:0]    q_i,
  output suvm_pkg::ctl_t              ctl_o,
  output logic [suvm_pkg::N_W-1:0]    rem_o,
  output logic [suvm_pkg::W_W-1:0]    d_o,
  output logic [suvm_pkg::Q_W-1:0]    q_o
);
  import suvm_pkg::*;

  logic [N_W-1:0] sub;
  logic           ge;
  ctl_t           ctl_q;
  logic [N_W-1:0] rem_q;
  logic [W_W-1:0] d_q;
  logic [Q_W-1:0] q_q;

  assign sub = N_W'(d_i) << BIT;
  assign ge  = (rem_i >= sub);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= ge ? (rem_i - sub) : rem_i;
    d_q   <= d_i;
    q_q   <= {q_i[Q_W-2:0], ge};
  end

  assign ctl_o = ctl_q;
  assign rem_o = rem_q;
  assign d_o   = d_q;
  assign q_o   = q_q;

endmodule

>>> sim/spherical_uv_mapper_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spherical UV mapper testbench
// Drives vertex words through a directed table and then random vertices. It
// predicts tex_u, tex_v and the degenerate flag for each word that is not
// a CHECK row, and compares every result word, in order, against the queue.
// ----------------------------------------------------------------------------
module spherical_uv_mapper_unit_tb;
  import suvm_pkg::*;

  localparam int    LATENCY  = 54;
  localparam int    N_RANDOM = 1700;
  localparam logic  NO_CHECK = 1'b0;
  localparam logic  CHECK    = 1'b1;

  typedef struct {
    logic signed [COORD_BITS-1:0] x, y, z;
    logic                         fixed;
    uv_t                          uv;
  } vec_row_t;

  logic clk_i;
  logic rst_ni;
  logic start;
  pos_t pos_i;
  logic busy;
  logic valid_o;
  uv_t  uv_o;

  uv_t uv_pending_q[$];
  int  n_errors;
  bit  stim_done;

  spherical_uv_mapper_unit u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .pos_i   (pos_i),
    .busy    (busy),
    .valid_o (valid_o),
    .uv_o    (uv_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("tb: failure");
    $finish;
  end

  function automatic longint unsigned abs64(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  function automatic longint unsigned root64(longint unsigned s);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv >>= 2;
    while (bitv != 0) begin
      if (s >= res + bitv) begin
        s   = s - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic [UV_BITS-1:0] azimuth_u(longint x, longint z);
    longint unsigned m, q;
    longint          cx, cy, dx, dy, ang, a;
    int              sh;
    m  = abs64(x) > abs64(z) ? abs64(x) : abs64(z);
    sh = 0;
    if (m == 0) return UV_HALF;
    while (m < (64'd1 << 30)) begin
      m = m << 1;
      sh++;
    end
    cx  = z <<< sh;
    cy  = x <<< sh;
    ang = 0;
    if (cx < 0) begin
      cx  = -cx;
      cy  = -cy;
      ang = (x >= 0) ? (longint'(1) <<< 31) : -(longint'(1) <<< 31);
    end
    for (int i = 0; i < ROT_STEPS; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy > 0) begin
        cx += dx; cy -= dy; ang += longint'(TURN_TAB[i]);
      end else begin
        cx -= dx; cy += dy; ang -= longint'(TURN_TAB[i]);
      end
    end
    a = ang + (longint'(1) <<< 31);
    if (a < 0) a = 0;
    if (a > (longint'(1) <<< 32)) a = longint'(1) <<< 32;
    q = (longint'(a) + (64'd1 << (31 - UV_BITS))) >> (32 - UV_BITS);
    return q > UV_TOP ? UV_TOP : UV_BITS'(q);
  endfunction

  function automatic logic [UV_BITS-1:0] elevation_v(longint x, longint y, longint z);
    longint unsigned s, r, yq, w, q;
    int              k;
    s = abs64(x) * abs64(x) + abs64(y) * abs64(y) + abs64(z) * abs64(z);
    k = 0;
    while (s < (64'd1 << 60)) begin
      s = s << 2;
      k++;
    end
    r  = root64(s);
    yq = abs64(y) << k;
    w  = (y >= 0) ? r + yq : r - yq;
    q  = (2 * w * (64'd1 << (UV_BITS - 1)) + r) / (2 * r);
    return q > UV_TOP ? UV_TOP : UV_BITS'(q);
  endfunction

  function automatic uv_t map_vertex(pos_t p);
    uv_t    res;
    longint x, y, z;
    x = longint'(p.pos_x);
    y = longint'(p.pos_y);
    z = longint'(p.pos_z);
    if (x == 0 && y == 0 && z == 0) begin
      res.tex_u      = UV_HALF;
      res.tex_v      = UV_HALF;
      res.degenerate = 1'b1;
    end else begin
      res.tex_u      = azimuth_u(x, z);
      res.tex_v      = elevation_v(x, y, z);
      res.degenerate = 1'b0;
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
    n_errors++;
  endtask

  always @(posedge clk_i) begin
    uv_t want;
    if (rst_ni && valid_o) begin
      if (uv_pending_q.size() == 0) begin
        report_mismatch("unexpected word", 1, 0);
      end else begin
        want = uv_pending_q.pop_front();
        if (uv_o.tex_u !== want.tex_u) report_mismatch("tex_u", uv_o.tex_u, want.tex_u);
        if (uv_o.tex_v !== want.tex_v) report_mismatch("tex_v", uv_o.tex_v, want.tex_v);
        if (uv_o.degenerate !== want.degenerate)
          report_mismatch("degenerate", uv_o.degenerate, want.degenerate);
      end
    end
  end

  // Hold start high until the word is taken; drop it only while idling.
  task automatic send_vertex(pos_t p, uv_t want, int idle_cycles);
    pos_i <= p;
    start <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    uv_pending_q = {uv_pending_q, want};
    @(negedge clk_i);
    if (idle_cycles > 0) begin
      start <= 1'b0;
      repeat (idle_cycles) @(negedge clk_i);
    end
  endtask

  function automatic logic signed [COORD_BITS-1:0] rand_coord();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0: return '0;
      1: return {1'b0, {(COORD_BITS-1){1'b1}}};
      2: return {1'b1, {(COORD_BITS-1){1'b0}}};
      3, 4: return COORD_BITS'($signed($urandom_range(0, 64)) - 32);
      5: return COORD_BITS'($signed($urandom_range(0, 8190)) - 4095);
      default: return COORD_BITS'($urandom);
    endcase
  endfunction

  localparam logic signed [COORD_BITS-1:0] CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  vec_row_t directed_tab[] = '{
    '{0, 0, 0, CHECK, '{UV_HALF, UV_HALF, 1'b1}},
    '{0, 5, 0, CHECK, '{UV_HALF, UV_TOP, 1'b0}},
    '{0, CMAX, 0, CHECK, '{UV_HALF, UV_TOP, 1'b0}},
    '{0, -5, 0, CHECK, '{UV_HALF, 16'd0, 1'b0}},
    '{0, CMIN, 0, CHECK, '{UV_HALF, 16'd0, 1'b0}},
    '{0, 0, -1, CHECK, '{UV_TOP, UV_HALF, 1'b0}},
    '{0, 0, CMIN, CHECK, '{UV_TOP, UV_HALF, 1'b0}},
    '{0, 0, 1, NO_CHECK, '{'0, '0, 1'b0}},
    '{1, 0, 0, NO_CHECK, '{'0, '0, 1'b0}},
    '{-1, 0, 0, NO_CHECK, '{'0, '0, 1'b0}},
    '{CMAX, CMAX, CMAX, NO_CHECK, '{'0, '0, 1'b0}},
    '{CMIN, CMIN, CMIN, NO_CHECK, '{'0, '0, 1'b0}},
    '{CMIN, CMAX, CMIN, NO_CHECK, '{'0, '0, 1'b0}},
    '{CMAX, CMIN, CMIN, NO_CHECK, '{'0, '0, 1'b0}},
    '{-1, 0, -1, NO_CHECK, '{'0, '0, 1'b0}},
    '{1, 0, -1, NO_CHECK, '{'0, '0, 1'b0}},
    '{-1, 1, -1, NO_CHECK, '{'0, '0, 1'b0}},
    '{3, -4, 12, NO_CHECK, '{'0, '0, 1'b0}},
    '{CMIN, 0, CMAX, NO_CHECK, '{'0, '0, 1'b0}},
    '{-24'sd1, -24'sd1, 24'sd0, NO_CHECK, '{'0, '0, 1'b0}},
    '{24'sh555555, 24'shAAAAAA, 24'sh0F0F0F, NO_CHECK, '{'0, '0, 1'b0}}
  };

  initial begin
    pos_t p;
    uv_t  want;
    bit   quiet;
    int   idle;
    n_errors  = 0;
    stim_done = 0;
    rst_ni    = 1'b0;
    start     = 1'b0;
    pos_i     = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_tab[i]) begin
      p.pos_x = directed_tab[i].x;
      p.pos_y = directed_tab[i].y;
      p.pos_z = directed_tab[i].z;
      want = directed_tab[i].fixed ? directed_tab[i].uv : map_vertex(p);
      send_vertex(p, want, ((i % 3) == 0) ? 1 + (i % 2) : 0);
    end
    start <= 1'b0;
    while (uv_pending_q.size() != 0) @(negedge clk_i);

    for (int n = 0; n < N_RANDOM; n++) begin
      quiet = (n >= 600 && n < 900);
      if (n == 1200) begin
        start <= 1'b0;
        while (uv_pending_q.size() != 0) @(negedge clk_i);
      end
      p.pos_x = rand_coord();
      p.pos_y = rand_coord();
      p.pos_z = rand_coord();
      idle = (!quiet && $urandom_range(0, 99) < 12) ? 1 : 0;
      send_vertex(p, map_vertex(p), idle);
    end
    start <= 1'b0;
    stim_done = 1;
  end

  initial begin
    int wait_cycles;
    wait (stim_done);
    wait_cycles = 0;
    while (uv_pending_q.size() != 0 && wait_cycles < 10 * LATENCY) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (LATENCY + 4) @(posedge clk_i);
    if (n_errors == 0 && uv_pending_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
